>>> design/thti_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the terrain height interpolator.
// Used by every module of the block except thti_ram; depends on nothing else.
package thti_pkg;

    // Grid capacity.
    localparam int MAX_COLUMNS = 256;
    localparam int MAX_ROWS    = 256;
    localparam int GRID_DEPTH  = MAX_COLUMNS * MAX_ROWS;
    localparam int ADDR_BITS   = $clog2(GRID_DEPTH);

    // Field and arithmetic widths.
    localparam int DATA_W  = 32;
    localparam int COORD_W = DATA_W + 1;
    localparam int INV_W   = 24;
    localparam int DIM_W   = 9;
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = DATA_W + INV_W + 1;
    localparam int CELL_W  = PROD_W - 2 * FRAC_W;
    localparam int WT_W    = FRAC_W + 1;
    localparam int MAC_W   = DATA_W + WT_W + 1;
    localparam int ACC_W   = MAC_W + 2;
    localparam int SH_W    = ACC_W - FRAC_W;

    localparam logic [WT_W-1:0] ONE_Q = WT_W'(1) << FRAC_W;

    // Command queue between the front and back ends.
    localparam int CMD_DEPTH = 2;
    localparam int PTR_W     = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int CNT_W     = $clog2(CMD_DEPTH + 1);

    // Operation codes.
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_RES     = 2'd2;

    typedef struct packed {
        logic [DIM_W-1:0] grid_width;
        logic [DIM_W-1:0] grid_height;
        logic [INV_W-1:0] inv_resolution;
    } cfg_t;

    // One classified item as handed from the front end to the back end.
    typedef struct packed {
        logic [1:0]           kind;
        logic                 wr_en;
        logic [DATA_W-1:0]    wdata;
        logic [ADDR_BITS-1:0] addr_a;
        logic [ADDR_BITS-1:0] addr_b;
        logic [ADDR_BITS-1:0] addr_c;
        logic [WT_W-1:0]      wt_u;
        logic [WT_W-1:0]      wt_v;
        logic [WT_W-1:0]      wt_w;
    } cmd_t;

    // Last usable index along one axis; a size of zero acts as one and an
    // oversized value acts as the capacity.
    function automatic logic [31:0] last_idx(logic [DIM_W-1:0] n, int maxn);
        logic [31:0] lim;
        if (n == '0) begin
            lim = 32'd0;
        end
        else if (32'(n) > 32'(maxn)) begin
            lim = 32'(maxn) - 32'd1;
        end
        else begin
            lim = 32'(n) - 32'd1;
        end
        return lim;
    endfunction

    // Clamp a signed index into [0, last].
    function automatic logic [31:0] clamp_idx(logic signed [COORD_W-1:0] v,
                                              logic [DIM_W-1:0] n, int maxn);
        logic [31:0] lim;
        logic [31:0] r;
        lim = last_idx(n, maxn);
        if (v < 0) begin
            r = 32'd0;
        end
        else if (64'(v) > 64'(lim)) begin
            r = lim;
        end
        else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // True where the index lies inside the grid without clamping.
    function automatic logic in_range(logic signed [COORD_W-1:0] v,
                                      logic [DIM_W-1:0] n, int maxn);
        logic [31:0] lim;
        lim = last_idx(n, maxn);
        return (v >= 0) && (64'(v) <= 64'(lim));
    endfunction

    // Memory address of a clamped cell.
    function automatic logic [ADDR_BITS-1:0] cell_addr(logic signed [COORD_W-1:0] col,
                                                       logic signed [COORD_W-1:0] row,
                                                       logic [DIM_W-1:0] w,
                                                       logic [DIM_W-1:0] h);
        logic [31:0] c;
        logic [31:0] r;
        c = clamp_idx(col, w, MAX_COLUMNS);
        r = clamp_idx(row, h, MAX_ROWS);
        return ADDR_BITS'(r * 32'(MAX_COLUMNS) + c);
    endfunction

endpackage

>>> design/thti_ram.sv
`timescale 1ns / 1ps
// Generic single-port RAM with one write or read per cycle and registered read data.
// Stands alone; no package needed.
module thti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port share one address.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

>>> design/thti_front.sv
`timescale 1ns / 1ps
// Front end: accepts items, scales query coordinates and classifies each item into a command.
// Depends on thti_pkg.
module thti_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [1:0]                    operation,
    input  logic signed [31:0]            x_coord,
    input  logic signed [31:0]            y_coord,
    input  logic signed [31:0]            sample_value,
    input  thti_pkg::cfg_t                cfg,
    output logic                          cq_push,
    output thti_pkg::cmd_t                cq_cmd,
    input  logic                          cq_full
);

    localparam logic signed [thti_pkg::COORD_W-1:0] CELL_STEP = 1;

    logic                                  s1_valid_reg;
    logic [1:0]                            s1_op_reg;
    logic signed [thti_pkg::DATA_W-1:0]    s1_x_reg;
    logic signed [thti_pkg::DATA_W-1:0]    s1_y_reg;
    logic [thti_pkg::DATA_W-1:0]           s1_sample_reg;
    logic signed [thti_pkg::PROD_W-1:0]    s1_px_reg;
    logic signed [thti_pkg::PROD_W-1:0]    s1_py_reg;

    logic                                  accept;
    logic signed [thti_pkg::PROD_W-1:0]    px;
    logic signed [thti_pkg::PROD_W-1:0]    py;

    logic [thti_pkg::FRAC_W-1:0]           fx;
    logic [thti_pkg::FRAC_W-1:0]           fy;
    logic [thti_pkg::FRAC_W:0]             fsum;
    logic                                  side;
    logic [thti_pkg::WT_W-1:0]             wt_u;
    logic [thti_pkg::WT_W-1:0]             wt_v;
    logic [thti_pkg::WT_W-1:0]             wt_w;
    logic signed [thti_pkg::COORD_W-1:0]   cx;
    logic signed [thti_pkg::COORD_W-1:0]   cy;
    logic signed [thti_pkg::COORD_W-1:0]   side_step;
    logic signed [thti_pkg::COORD_W-1:0]   pt_x;
    logic signed [thti_pkg::COORD_W-1:0]   pt_y;

    // A new transaction is taken whenever the stage is free or drains this cycle.
    assign accept  = push && !full;
    assign full    = s1_valid_reg && cq_full;
    assign cq_push = s1_valid_reg && !cq_full;

    // Scale both world coordinates by the inverse resolution.
    assign px = $signed(x_coord) * $signed({1'b0, cfg.inv_resolution});
    assign py = $signed(y_coord) * $signed({1'b0, cfg.inv_resolution});

    // Stage occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (cq_push)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg     <= operation;
            s1_x_reg      <= x_coord;
            s1_y_reg      <= y_coord;
            s1_sample_reg <= sample_value;
            s1_px_reg     <= px;
            s1_py_reg     <= py;
        end
    end

    // Split the scaled values into cell and fraction, and pick the triangle.
    always_comb
    begin
        fx   = s1_px_reg[2*thti_pkg::FRAC_W-1:thti_pkg::FRAC_W];
        fy   = s1_py_reg[2*thti_pkg::FRAC_W-1:thti_pkg::FRAC_W];
        fsum = {1'b0, fx} + {1'b0, fy};
        side = fsum[thti_pkg::FRAC_W];
        cx   = $signed({{(thti_pkg::COORD_W-thti_pkg::CELL_W){s1_px_reg[thti_pkg::PROD_W-1]}},
                        s1_px_reg[thti_pkg::PROD_W-1:2*thti_pkg::FRAC_W]});
        cy   = $signed({{(thti_pkg::COORD_W-thti_pkg::CELL_W){s1_py_reg[thti_pkg::PROD_W-1]}},
                        s1_py_reg[thti_pkg::PROD_W-1:2*thti_pkg::FRAC_W]});
        side_step = $signed({{(thti_pkg::COORD_W-1){1'b0}}, side});
        wt_v = side ? (thti_pkg::ONE_Q - {1'b0, fy}) : {1'b0, fx};
        wt_w = side ? (thti_pkg::ONE_Q - {1'b0, fx}) : {1'b0, fy};
        wt_u = thti_pkg::ONE_Q - wt_v - wt_w;
        pt_x = $signed({s1_x_reg[thti_pkg::DATA_W-1], s1_x_reg});
        pt_y = $signed({s1_y_reg[thti_pkg::DATA_W-1], s1_y_reg});
    end

    // Build the command for the back end.
    always_comb
    begin
        cq_cmd       = '0;
        cq_cmd.kind  = s1_op_reg;
        cq_cmd.wdata = s1_sample_reg;
        case (s1_op_reg)
            thti_pkg::OP_WRITE:
            begin
                cq_cmd.addr_a = thti_pkg::cell_addr(pt_x, pt_y, cfg.grid_width,
                                                    cfg.grid_height);
                cq_cmd.wr_en  = thti_pkg::in_range(pt_x, cfg.grid_width, thti_pkg::MAX_COLUMNS)
                             && thti_pkg::in_range(pt_y, cfg.grid_height, thti_pkg::MAX_ROWS);
            end
            thti_pkg::OP_READ:
            begin
                cq_cmd.addr_a = thti_pkg::cell_addr(pt_x, pt_y, cfg.grid_width,
                                                    cfg.grid_height);
            end
            thti_pkg::OP_QUERY:
            begin
                cq_cmd.addr_a = thti_pkg::cell_addr(cx + side_step, cy + side_step,
                                                    cfg.grid_width, cfg.grid_height);
                cq_cmd.addr_b = thti_pkg::cell_addr(cx + CELL_STEP, cy,
                                                    cfg.grid_width, cfg.grid_height);
                cq_cmd.addr_c = thti_pkg::cell_addr(cx, cy + CELL_STEP,
                                                    cfg.grid_width, cfg.grid_height);
                cq_cmd.wt_u   = wt_u;
                cq_cmd.wt_v   = wt_v;
                cq_cmd.wt_w   = wt_w;
            end
            default:
            begin
                cq_cmd.wr_en = 1'b0;
            end
        endcase
    end

endmodule

>>> design/thti_cmd_fifo.sv
`timescale 1ns / 1ps
// Short command queue between the front end and the back end.
// Depends on thti_pkg.
module thti_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  thti_pkg::cmd_t cmd_in,
    output logic           full,
    input  logic           pop,
    output thti_pkg::cmd_t cmd_out,
    output logic           empty
);

    thti_pkg::cmd_t                entry_reg [thti_pkg::CMD_DEPTH];
    logic [thti_pkg::PTR_W-1:0]    wr_ptr_reg;
    logic [thti_pkg::PTR_W-1:0]    rd_ptr_reg;
    logic [thti_pkg::CNT_W-1:0]    count_reg;
    logic [thti_pkg::PTR_W-1:0]    wr_ptr_next;
    logic [thti_pkg::PTR_W-1:0]    rd_ptr_next;
    logic [thti_pkg::CNT_W-1:0]    count_next;

    assign full    = (count_reg == thti_pkg::CNT_W'(thti_pkg::CMD_DEPTH));
    assign empty   = (count_reg == '0);
    assign cmd_out = entry_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == thti_pkg::PTR_W'(thti_pkg::CMD_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == thti_pkg::PTR_W'(thti_pkg::CMD_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + thti_pkg::CNT_W'(push) - thti_pkg::CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

>>> design/thti_back.sv
`timescale 1ns / 1ps
// Back end: runs commands against the height memory and blends the three corner samples.
// Depends on thti_pkg and thti_ram.
module thti_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  thti_pkg::cmd_t                cq_cmd,
    input  logic                          cq_empty,
    output logic                          cq_pop,
    output logic                          empty,
    input  logic                          pop,
    output logic signed [31:0]            height_out
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_QB   = 3'd2;
    localparam logic [2:0] ST_QC   = 3'd3;
    localparam logic [2:0] ST_QD   = 3'd4;
    localparam logic [2:0] ST_QE   = 3'd5;

    localparam logic signed [thti_pkg::SH_W-1:0] SAT_HI =
        {{(thti_pkg::SH_W-thti_pkg::DATA_W+1){1'b0}}, {(thti_pkg::DATA_W-1){1'b1}}};
    localparam logic signed [thti_pkg::SH_W-1:0] SAT_LO =
        {{(thti_pkg::SH_W-thti_pkg::DATA_W+1){1'b1}}, {(thti_pkg::DATA_W-1){1'b0}}};

    logic [2:0]                           state_reg;
    logic [2:0]                           state_next;
    logic                                 res_valid_reg;
    logic                                 res_valid_next;
    logic [thti_pkg::DATA_W-1:0]          res_data_reg;
    thti_pkg::cmd_t                       cur_reg;
    logic signed [thti_pkg::MAC_W-1:0]    prod_reg;
    logic signed [thti_pkg::ACC_W-1:0]    acc_reg;

    logic                                 start;
    logic                                 res_load;
    logic [thti_pkg::DATA_W-1:0]          res_value;
    logic                                 ram_we;
    logic [thti_pkg::ADDR_BITS-1:0]       ram_addr;
    logic [thti_pkg::DATA_W-1:0]          ram_wdata;
    logic [thti_pkg::DATA_W-1:0]          ram_rdata;
    logic [thti_pkg::WT_W-1:0]            wt_sel;
    logic signed [thti_pkg::MAC_W-1:0]    mult;
    logic signed [thti_pkg::ACC_W-1:0]    prod_ext;
    logic signed [thti_pkg::ACC_W-1:0]    sum;
    logic signed [thti_pkg::SH_W-1:0]     shifted;
    logic [thti_pkg::DATA_W-1:0]          sat;

    thti_ram #(
        .WIDTH (thti_pkg::DATA_W),
        .DEPTH (thti_pkg::GRID_DEPTH)
    ) u_height_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Weighted corner sample; registered before it is accumulated.
    assign mult     = $signed(ram_rdata) * $signed({1'b0, wt_sel});
    assign prod_ext = {{(thti_pkg::ACC_W-thti_pkg::MAC_W){prod_reg[thti_pkg::MAC_W-1]}},
                       prod_reg};

    // Final sum, scaled back to Q16.16 with floor and saturated.
    always_comb
    begin
        sum     = acc_reg + prod_ext;
        shifted = sum[thti_pkg::ACC_W-1:thti_pkg::FRAC_W];
        if (shifted > SAT_HI)
        begin
            sat = SAT_HI[thti_pkg::DATA_W-1:0];
        end
        else if (shifted < SAT_LO)
        begin
            sat = SAT_LO[thti_pkg::DATA_W-1:0];
        end
        else
        begin
            sat = shifted[thti_pkg::DATA_W-1:0];
        end
    end

    // Sequencer: one command at a time, three memory reads for a query.
    always_comb
    begin
        start      = (state_reg == ST_IDLE) && !cq_empty && (!res_valid_reg || pop);
        cq_pop     = start;
        ram_addr   = cur_reg.addr_a;
        ram_we     = 1'b0;
        ram_wdata  = cq_cmd.wdata;
        wt_sel     = cur_reg.wt_u;
        state_next = state_reg;
        res_load   = 1'b0;
        res_value  = res_data_reg;
        case (state_reg)
            ST_IDLE:
            begin
                ram_addr = cq_cmd.addr_a;
                if (start)
                begin
                    case (cq_cmd.kind)
                        thti_pkg::OP_WRITE:
                        begin
                            ram_we    = cq_cmd.wr_en;
                            res_load  = 1'b1;
                            res_value = cq_cmd.wdata;
                        end
                        thti_pkg::OP_READ:
                        begin
                            state_next = ST_RD;
                        end
                        thti_pkg::OP_QUERY:
                        begin
                            state_next = ST_QB;
                        end
                        default:
                        begin
                            res_load  = 1'b1;
                            res_value = '0;
                        end
                    endcase
                end
            end
            ST_RD:
            begin
                res_load   = 1'b1;
                res_value  = ram_rdata;
                state_next = ST_IDLE;
            end
            ST_QB:
            begin
                ram_addr   = cur_reg.addr_b;
                wt_sel     = cur_reg.wt_u;
                state_next = ST_QC;
            end
            ST_QC:
            begin
                ram_addr   = cur_reg.addr_c;
                wt_sel     = cur_reg.wt_v;
                state_next = ST_QD;
            end
            ST_QD:
            begin
                wt_sel     = cur_reg.wt_w;
                state_next = ST_QE;
            end
            ST_QE:
            begin
                res_load   = 1'b1;
                res_value  = sat;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        res_valid_next = res_load ? 1'b1 : (res_valid_reg && !pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cur_reg <= cq_cmd;
        end
        if (res_load)
        begin
            res_data_reg <= res_value;
        end
        prod_reg <= mult;
        if (state_reg == ST_QC)
        begin
            acc_reg <= prod_ext;
        end
        else if (state_reg == ST_QD)
        begin
            acc_reg <= sum;
        end
    end

    assign empty      = !res_valid_reg;
    assign height_out = res_data_reg;

`ifndef ASSERT_OFF
    // A query walks through its three reads without a break.
    a_query_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_QB) |=> (state_reg == ST_QC))
        else $error("query sequence broken after first read");

    // While a read or query is in progress no earlier result is still waiting.
    a_busy_result_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !res_valid_reg)
        else $error("result register occupied while a command is running");

    // A read produces its result on the following cycle.
    a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD) |=> res_valid_reg)
        else $error("read finished without a result");

    // The three barycentric weights of a query always sum to one.
    a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (start && (cq_cmd.kind == thti_pkg::OP_QUERY)) |->
        (({1'b0, cq_cmd.wt_u} + {1'b0, cq_cmd.wt_v} + {1'b0, cq_cmd.wt_w})
            == {1'b0, thti_pkg::ONE_Q}))
        else $error("query weights do not sum to one");

    // The memory is only written for a write command taken from the queue.
    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (start && (cq_cmd.kind == thti_pkg::OP_WRITE)))
        else $error("memory written outside a write command");
`endif

endmodule

>>> design/terrain_height_triangle_interp.sv
`timescale 1ns / 1ps
// Top level of the terrain height store with barycentric triangle interpolation.
// Depends on thti_pkg, thti_front, thti_cmd_fifo and thti_back (which holds thti_ram).

// The block holds a 256 x 256 grid of Q16.16 height samples in a single-ported
// memory and takes write, read and query transactions through a queue-style
// input; every transaction returns one result on the queue-style output. The
// front end scales and classifies each item in a registered stage and can take a
// new one every cycle while the two-entry command queue has room. The back end
// owns the memory port and sets the sustained rate: a write completes as it is
// taken, a read passes through ST_RD and a query through ST_QB to ST_QE (three
// corner reads through the one memory port, then the multiply-accumulate that
// follows the last read). The memory is not cleared after reset: a cell must be
// written before any read or query touches it. Configuration writes are
// accepted every cycle and must be made only while no transaction is in flight.
module terrain_height_triangle_interp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [1:0]                          operation,
    input  logic signed [31:0]                  x_coord,
    input  logic signed [31:0]                  y_coord,
    input  logic signed [31:0]                  sample_value,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [31:0]                  height_out,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [thti_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [thti_pkg::INV_W-1:0]          cfg_data
);

    thti_pkg::cfg_t cfg_reg;
    thti_pkg::cmd_t fe_cmd;
    thti_pkg::cmd_t cq_cmd;
    logic           fe_push;
    logic           cq_full;
    logic           cq_empty;
    logic           cq_pop;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grid_width     <= thti_pkg::DIM_W'(256);
            cfg_reg.grid_height    <= thti_pkg::DIM_W'(256);
            cfg_reg.inv_resolution <= thti_pkg::INV_W'(65536);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                thti_pkg::REG_GRID_WIDTH:
                begin
                    cfg_reg.grid_width <= cfg_data[thti_pkg::DIM_W-1:0];
                end
                thti_pkg::REG_GRID_HEIGHT:
                begin
                    cfg_reg.grid_height <= cfg_data[thti_pkg::DIM_W-1:0];
                end
                thti_pkg::REG_INV_RES:
                begin
                    cfg_reg.inv_resolution <= cfg_data;
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    thti_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .operation    (operation),
        .x_coord      (x_coord),
        .y_coord      (y_coord),
        .sample_value (sample_value),
        .cfg          (cfg_reg),
        .cq_push      (fe_push),
        .cq_cmd       (fe_cmd),
        .cq_full      (cq_full)
    );

    thti_cmd_fifo u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (fe_push),
        .cmd_in  (fe_cmd),
        .full    (cq_full),
        .pop     (cq_pop),
        .cmd_out (cq_cmd),
        .empty   (cq_empty)
    );

    thti_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cq_cmd     (cq_cmd),
        .cq_empty   (cq_empty),
        .cq_pop     (cq_pop),
        .empty      (empty),
        .pop        (pop),
        .height_out (height_out)
    );

endmodule
